// ===== rtl/closest_point_on_triangle_top_macros.svh =====
// ----------------------------------------------------------------------------
// closest point on triangle assertion macros
// shared concurrent check forms, clocked on aclk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_TRIANGLE_TOP_MACROS_SVH
`define CLOSEST_POINT_ON_TRIANGLE_TOP_MACROS_SVH

// same-cycle implication
`define CPT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cpt_pkg.sv =====
// ----------------------------------------------------------------------------
// cpt_pkg
// widths, region codes and shared types of the closest point on triangle block
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int CRD_W     = 32;               // q16.16 coordinate
    localparam int DIFF_W    = CRD_W + 1;        // exact vertex difference
    localparam int PROD_W    = 2 * DIFF_W;       // one dot product term
    localparam int PSUM_W    = PROD_W + 2;       // sum of three terms
    localparam int FRAC_W    = 16;
    localparam int DOT_W     = 51;               // dot product after shift
    localparam int LO_W      = 26;               // low half of a split dot value
    localparam int HI_W      = DOT_W - LO_W;
    localparam int MIX_W     = HI_W + LO_W + 1;  // signed by unsigned partial
    localparam int VW        = 104;              // barycentric numerators and sum
    localparam int EDGE_W    = DOT_W + 2;
    localparam int DIV_STEPS = 31;
    localparam int DIV_RW    = VW + DIV_STEPS + 1;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int RATIO_W   = 32;
    localparam int LERP_W    = DIFF_W + RATIO_W;
    localparam int SAT_SHIFT = 15;
    localparam int IN_W      = 12 * CRD_W;
    localparam int OUT_W     = 3 * CRD_W;

    localparam logic [2:0] RG_A    = 3'd0;
    localparam logic [2:0] RG_B    = 3'd1;
    localparam logic [2:0] RG_C    = 3'd2;
    localparam logic [2:0] RG_AB   = 3'd3;
    localparam logic [2:0] RG_AC   = 3'd4;
    localparam logic [2:0] RG_BC   = 3'd5;
    localparam logic [2:0] RG_FACE = 3'd6;

    typedef logic [2:0][CRD_W-1:0]  vec_crd_t;
    typedef logic [2:0][DIFF_W-1:0] vec_diff_t;

    // magnitudes and result sign for one ratio
    typedef struct packed {
        logic [VW-1:0] num;
        logic [VW-1:0] den;
        logic          neg;
    } div_in_t;

    // what the output stages need besides the two ratios
    typedef struct packed {
        logic [2:0] region;
        vec_crd_t   base;
        vec_diff_t  dir1;
        vec_diff_t  dir2;
    } side_t;

endpackage

// ===== rtl/cpt_div.sv =====
// ----------------------------------------------------------------------------
// cpt_div
// pipelined restoring divider, q16.16 ratio of two magnitudes, saturating
// ----------------------------------------------------------------------------
module cpt_div
    import cpt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      adv,
    input  div_in_t                   din,
    output logic signed [RATIO_W-1:0] ratio
);

    typedef struct packed {
        logic neg;
        logic sat;
        logic zero;
    } div_flag_t;

    logic [DIV_RW-1:0]         rem_reg  [DIV_STEPS+1];
    logic [VW-1:0]             den_reg  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0]      quo_reg  [DIV_STEPS+1];
    div_flag_t                 flg_reg  [DIV_STEPS+1];
    logic signed [RATIO_W-1:0] ratio_reg;

    logic [DIV_RW-1:0]         rem_next [DIV_STEPS+1];
    logic [DIV_STEPS-1:0]      quo_next [DIV_STEPS+1];
    logic [DIV_RW-1:0]         step_den [DIV_STEPS+1];
    logic [DIV_STEPS:0]        step_ge;
    div_flag_t                 flg_next;
    logic signed [RATIO_W-1:0] ratio_next;
    logic [DIV_RW-1:0]         num_ext;

    always_comb begin
        // entry: saturation test num >= den * 2^15
        num_ext        = DIV_RW'(din.num);
        step_den[0]    = DIV_RW'(din.den) << SAT_SHIFT;
        step_ge[0]     = (num_ext >= step_den[0]);
        flg_next.zero  = (din.den == '0);
        flg_next.sat   = step_ge[0] && !flg_next.zero;
        flg_next.neg   = din.neg;
        rem_next[0]    = num_ext << FRAC_W;
        quo_next[0]    = '0;
        // one quotient bit per stage, msb first
        for (int s = 1; s <= DIV_STEPS; s++) begin
            step_den[s] = DIV_RW'(den_reg[s-1]) << (DIV_STEPS - s);
            step_ge[s]  = (rem_reg[s-1] >= step_den[s]);
            rem_next[s] = step_ge[s] ? (rem_reg[s-1] - step_den[s]) : rem_reg[s-1];
            quo_next[s] = {quo_reg[s-1][DIV_STEPS-2:0], step_ge[s]};
        end
    end

    always_comb begin
        if (flg_reg[DIV_STEPS].zero) begin
            ratio_next = '0;
        end else if (flg_reg[DIV_STEPS].sat) begin
            ratio_next = flg_reg[DIV_STEPS].neg ? {1'b1, {(RATIO_W-1){1'b0}}}
                                                : {1'b0, {(RATIO_W-1){1'b1}}};
        end else if (flg_reg[DIV_STEPS].neg) begin
            ratio_next = -$signed({1'b0, quo_reg[DIV_STEPS]});
        end else begin
            ratio_next = $signed({1'b0, quo_reg[DIV_STEPS]});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            den_reg[0] <= din.den;
            flg_reg[0] <= flg_next;
            for (int s = 0; s <= DIV_STEPS; s++) begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
            for (int s = 1; s <= DIV_STEPS; s++) begin
                den_reg[s] <= den_reg[s-1];
                flg_reg[s] <= flg_reg[s-1];
            end
            ratio_reg <= ratio_next;
        end
    end

    assign ratio = ratio_reg;

endmodule

// ===== rtl/closest_point_on_triangle_top.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_triangle_top
// nearest point of triangle abc to query point p, q16.16, fully pipelined
// ----------------------------------------------------------------------------
//
//   channel  | direction | tdata fields, lowest bit up
//   ---------+-----------+------------------------------------------------
//   s_       | in        | point xyz, vert_a xyz, vert_b xyz, vert_c xyz
//   m_       | out       | nearest_x, nearest_y, nearest_z
//
// one transaction enters per cycle unless the output is held
// most of the latency lies in the two 31-step restoring dividers, one quotient bit per stage
// reset clears only the valid line; data registers are not reset
// a held output (m_tvalid high, m_tready low) freezes every stage and drops s_tready
// nothing is lost or repeated across a stall since all stages share one enable
//
`include "closest_point_on_triangle_top_macros.svh"

module closest_point_on_triangle_top
    import cpt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // nearest_x, nearest_y, nearest_z
    output logic [OUT_W-1:0] m_tdata
);

    localparam int NSTG      = 8 + DIV_LAT + 2;   // total register stages
    localparam int ST8       = 7;                 // valid index of stage 8
    localparam int ST_L1     = 8 + DIV_LAT;       // valid index of lerp products
    localparam int RATIO_ONE = 1 << FRAC_W;

    // which dot products pair up into the barycentric numerators
    localparam int PX [6] = '{0, 2, 4, 0, 2, 4};
    localparam int PY [6] = '{3, 1, 1, 5, 5, 3};

    typedef struct packed {
        vec_crd_t  a;
        vec_crd_t  b;
        vec_crd_t  c;
        vec_diff_t ab;
        vec_diff_t ac;
        vec_diff_t bc;
    } geo_t;

    function automatic logic [DIFF_W-1:0] sdiff(input logic [CRD_W-1:0] x,
                                                input logic [CRD_W-1:0] y);
        return {x[CRD_W-1], x} - {y[CRD_W-1], y};
    endfunction

    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] x);
        return x[VW-1] ? -x : x;
    endfunction

    // global advance: the whole pipe moves unless the output is held
    logic            adv;
    logic [NSTG-1:0] vld_reg;

    assign adv      = !vld_reg[NSTG-1] || m_tready;
    // no transaction is taken while in reset
    assign s_tready = adv && aresetn;
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // ---------------- stage 1: vertex differences ----------------
    geo_t      geo_next;
    geo_t      geo_reg [7];
    vec_diff_t pv_next [3];
    vec_diff_t pv_reg  [3];   // ap, bp, cp

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            geo_next.a[i]  = s_tdata[(3 + i) * CRD_W +: CRD_W];
            geo_next.b[i]  = s_tdata[(6 + i) * CRD_W +: CRD_W];
            geo_next.c[i]  = s_tdata[(9 + i) * CRD_W +: CRD_W];
            geo_next.ab[i] = sdiff(geo_next.b[i], geo_next.a[i]);
            geo_next.ac[i] = sdiff(geo_next.c[i], geo_next.a[i]);
            geo_next.bc[i] = sdiff(geo_next.c[i], geo_next.b[i]);
            pv_next[0][i]  = sdiff(s_tdata[i * CRD_W +: CRD_W], geo_next.a[i]);
            pv_next[1][i]  = sdiff(s_tdata[i * CRD_W +: CRD_W], geo_next.b[i]);
            pv_next[2][i]  = sdiff(s_tdata[i * CRD_W +: CRD_W], geo_next.c[i]);
        end
    end

    // ---------------- stage 2: dot product terms ----------------
    // term order d1..d6: ab.ap, ac.ap, ab.bp, ac.bp, ab.cp, ac.cp
    logic signed [PROD_W-1:0] prod_next [6][3];
    logic signed [PROD_W-1:0] prod_reg  [6][3];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < 3; i++) begin
                if ((k & 1) == 0) begin
                    prod_next[k][i] = PROD_W'($signed(geo_reg[0].ab[i]))
                                    * PROD_W'($signed(pv_reg[k >> 1][i]));
                end else begin
                    prod_next[k][i] = PROD_W'($signed(geo_reg[0].ac[i]))
                                    * PROD_W'($signed(pv_reg[k >> 1][i]));
                end
            end
        end
    end

    // ---------------- stage 3: dot sums, floor to q16.16 ----------------
    logic signed [DOT_W-1:0] d3_next [6];
    logic signed [DOT_W-1:0] d3_reg  [6];

    always_comb begin
        logic signed [PSUM_W-1:0] psum;
        for (int k = 0; k < 6; k++) begin
            psum       = PSUM_W'(prod_reg[k][0]) + PSUM_W'(prod_reg[k][1])
                       + PSUM_W'(prod_reg[k][2]);
            d3_next[k] = psum[FRAC_W +: DOT_W];
        end
    end

    // ---------------- stage 4: split partial products ----------------
    logic        [2*LO_W-1:0] ll_next [6];
    logic signed [MIX_W-1:0]  hl_next [6];
    logic signed [MIX_W-1:0]  lh_next [6];
    logic signed [2*HI_W-1:0] hh_next [6];
    logic        [2*LO_W-1:0] ll_reg  [6];
    logic signed [MIX_W-1:0]  hl_reg  [6];
    logic signed [MIX_W-1:0]  lh_reg  [6];
    logic signed [2*HI_W-1:0] hh_reg  [6];
    logic signed [DOT_W-1:0]  d4_reg  [6];

    always_comb begin
        for (int m = 0; m < 6; m++) begin
            ll_next[m] = (2*LO_W)'(d3_reg[PX[m]][LO_W-1:0])
                       * (2*LO_W)'(d3_reg[PY[m]][LO_W-1:0]);
            hl_next[m] = MIX_W'($signed(d3_reg[PX[m]][DOT_W-1:LO_W]))
                       * MIX_W'($signed({1'b0, d3_reg[PY[m]][LO_W-1:0]}));
            lh_next[m] = MIX_W'($signed({1'b0, d3_reg[PX[m]][LO_W-1:0]}))
                       * MIX_W'($signed(d3_reg[PY[m]][DOT_W-1:LO_W]));
            hh_next[m] = (2*HI_W)'($signed(d3_reg[PX[m]][DOT_W-1:LO_W]))
                       * (2*HI_W)'($signed(d3_reg[PY[m]][DOT_W-1:LO_W]));
        end
    end

    // ---------------- stage 5: recombine wide products ----------------
    logic signed [VW-1:0]    vp_next [6];
    logic signed [VW-1:0]    vp_reg  [6];
    logic signed [DOT_W-1:0] d5_reg  [6];

    always_comb begin
        logic signed [VW-1:0] t_hh;
        logic signed [VW-1:0] t_hl;
        logic signed [VW-1:0] t_lh;
        logic signed [VW-1:0] t_ll;
        for (int m = 0; m < 6; m++) begin
            t_hh       = VW'(hh_reg[m]);
            t_hl       = VW'(hl_reg[m]);
            t_lh       = VW'(lh_reg[m]);
            t_ll       = $signed(VW'(ll_reg[m]));
            vp_next[m] = (t_hh <<< (2 * LO_W)) + ((t_hl + t_lh) <<< LO_W) + t_ll;
        end
    end

    // ---------------- stage 6: vc, vb, va and bc edge terms ----------------
    logic signed [VW-1:0]    v_next [3];   // vc, vb, va
    logic signed [VW-1:0]    v_reg  [3];
    logic signed [DOT_W:0]   e43_next, e56_next, e43_reg, e56_reg;
    logic signed [DOT_W-1:0] d6_reg [6];

    always_comb begin
        v_next[0] = vp_reg[0] - vp_reg[1];
        v_next[1] = vp_reg[2] - vp_reg[3];
        v_next[2] = vp_reg[4] - vp_reg[5];
        e43_next  = (DOT_W+1)'(d5_reg[3]) - (DOT_W+1)'(d5_reg[2]);
        e56_next  = (DOT_W+1)'(d5_reg[4]) - (DOT_W+1)'(d5_reg[5]);
    end

    // ---------------- stage 7: region test, face denominator ----------------
    logic [2:0]              rg_next, rg_reg;
    logic signed [VW-1:0]    den_next, den_reg;
    logic signed [DOT_W:0]   dab_next, dac_next, dab_reg, dac_reg;
    logic signed [EDGE_W-1:0] dbc_next, dbc_reg;
    logic signed [VW-1:0]    vb7_reg, vc7_reg;
    logic signed [DOT_W-1:0] d1_7_reg, d2_7_reg;
    logic signed [DOT_W:0]   e43_7_reg;

    always_comb begin
        den_next = v_reg[0] + v_reg[1] + v_reg[2];
        dab_next = (DOT_W+1)'(d6_reg[0]) - (DOT_W+1)'(d6_reg[2]);
        dac_next = (DOT_W+1)'(d6_reg[1]) - (DOT_W+1)'(d6_reg[5]);
        dbc_next = EDGE_W'(e43_reg) + EDGE_W'(e56_reg);
        // voronoi tests in priority order
        if (d6_reg[0] <= 0 && d6_reg[1] <= 0) begin
            rg_next = RG_A;
        end else if (d6_reg[2] >= 0 && d6_reg[3] <= d6_reg[2]) begin
            rg_next = RG_B;
        end else if (v_reg[0] <= 0 && d6_reg[0] >= 0 && d6_reg[2] <= 0) begin
            rg_next = RG_AB;
        end else if (d6_reg[5] >= 0 && d6_reg[4] <= d6_reg[5]) begin
            rg_next = RG_C;
        end else if (v_reg[1] <= 0 && d6_reg[1] >= 0 && d6_reg[5] <= 0) begin
            rg_next = RG_AC;
        end else if (v_reg[2] <= 0 && e43_reg >= 0 && e56_reg >= 0) begin
            rg_next = RG_BC;
        end else begin
            rg_next = RG_FACE;
        end
    end

    // ---------------- stage 8: divider operands and output terms ----------------
    logic [2:0] rg_fin;
    div_in_t    din1_next, din2_next, din1_reg, din2_reg;
    side_t      side_next, s8_side_reg;

    always_comb begin
        // degenerate triangle falls back to vertex a
        rg_fin = (rg_reg == RG_FACE && den_reg == '0) ? RG_A : rg_reg;
        side_next.region = rg_fin;
        side_next.base   = geo_reg[6].a;
        side_next.dir1   = '0;
        side_next.dir2   = '0;
        din1_next        = '0;
        din2_next        = '0;
        case (rg_fin)
            RG_A: begin
                side_next.base = geo_reg[6].a;
            end
            RG_B: begin
                side_next.base = geo_reg[6].b;
            end
            RG_C: begin
                side_next.base = geo_reg[6].c;
            end
            RG_AB: begin
                side_next.dir1 = geo_reg[6].ab;
                din1_next.num  = {{(VW-DOT_W){1'b0}}, d1_7_reg};
                din1_next.den  = {{(VW-DOT_W-1){1'b0}}, dab_reg};
            end
            RG_AC: begin
                side_next.dir1 = geo_reg[6].ac;
                din1_next.num  = {{(VW-DOT_W){1'b0}}, d2_7_reg};
                din1_next.den  = {{(VW-DOT_W-1){1'b0}}, dac_reg};
            end
            RG_BC: begin
                side_next.base = geo_reg[6].b;
                side_next.dir1 = geo_reg[6].bc;
                din1_next.num  = {{(VW-DOT_W-1){1'b0}}, e43_7_reg};
                din1_next.den  = {{(VW-EDGE_W){1'b0}}, dbc_reg};
            end
            RG_FACE: begin
                side_next.dir1 = geo_reg[6].ab;
                side_next.dir2 = geo_reg[6].ac;
                din1_next.num  = mag(vb7_reg);
                din1_next.den  = mag(den_reg);
                din1_next.neg  = vb7_reg[VW-1] ^ den_reg[VW-1];
                din2_next.num  = mag(vc7_reg);
                din2_next.den  = mag(den_reg);
                din2_next.neg  = vc7_reg[VW-1] ^ den_reg[VW-1];
            end
            default: begin
                side_next.base = geo_reg[6].a;
            end
        endcase
    end

    // ---------------- stages 9 to 41: two dividers, side data alongside ----------------
    logic signed [RATIO_W-1:0] ratio1, ratio2;
    side_t                     side_reg [DIV_LAT];

    cpt_div u_div_v (
        .aclk  (aclk),
        .adv   (adv),
        .din   (din1_reg),
        .ratio (ratio1)
    );

    cpt_div u_div_w (
        .aclk  (aclk),
        .adv   (adv),
        .din   (din2_reg),
        .ratio (ratio2)
    );

    // ---------------- stage 42: direction times ratio ----------------
    logic signed [LERP_W-1:0] lp1_next [3];
    logic signed [LERP_W-1:0] lp2_next [3];
    logic signed [LERP_W-1:0] lp1_reg  [3];
    logic signed [LERP_W-1:0] lp2_reg  [3];
    vec_crd_t                 l1_base_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lp1_next[i] = LERP_W'($signed(side_reg[DIV_LAT-1].dir1[i])) * LERP_W'(ratio1);
            lp2_next[i] = LERP_W'($signed(side_reg[DIV_LAT-1].dir2[i])) * LERP_W'(ratio2);
        end
    end

    // ---------------- stage 43: sum and saturate ----------------
    logic [OUT_W-1:0] out_next, out_reg;

    always_comb begin
        logic signed [LERP_W:0] acc;
        for (int i = 0; i < 3; i++) begin
            acc = (LERP_W+1)'($signed(l1_base_reg[i]))
                + (LERP_W+1)'(lp1_reg[i] >>> FRAC_W)
                + (LERP_W+1)'(lp2_reg[i] >>> FRAC_W);
            if (acc[LERP_W:CRD_W-1] == '0 || acc[LERP_W:CRD_W-1] == '1) begin
                out_next[i * CRD_W +: CRD_W] = acc[CRD_W-1:0];
            end else if (acc[LERP_W]) begin
                out_next[i * CRD_W +: CRD_W] = {1'b1, {(CRD_W-1){1'b0}}};
            end else begin
                out_next[i * CRD_W +: CRD_W] = {1'b0, {(CRD_W-1){1'b1}}};
            end
        end
    end

    assign m_tdata = out_reg;

    // ---------------- payload registers, all on the common advance ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            geo_reg[0] <= geo_next;
            for (int j = 1; j < 7; j++) begin
                geo_reg[j] <= geo_reg[j-1];
            end
            pv_reg   <= pv_next;
            prod_reg <= prod_next;
            d3_reg   <= d3_next;
            ll_reg   <= ll_next;
            hl_reg   <= hl_next;
            lh_reg   <= lh_next;
            hh_reg   <= hh_next;
            d4_reg   <= d3_reg;
            vp_reg   <= vp_next;
            d5_reg   <= d4_reg;
            v_reg    <= v_next;
            e43_reg  <= e43_next;
            e56_reg  <= e56_next;
            d6_reg   <= d5_reg;
            rg_reg    <= rg_next;
            den_reg   <= den_next;
            dab_reg   <= dab_next;
            dac_reg   <= dac_next;
            dbc_reg   <= dbc_next;
            vb7_reg   <= v_reg[1];
            vc7_reg   <= v_reg[0];
            d1_7_reg  <= d6_reg[0];
            d2_7_reg  <= d6_reg[1];
            e43_7_reg <= e43_reg;
            din1_reg    <= din1_next;
            din2_reg    <= din2_next;
            s8_side_reg <= side_next;
            side_reg[0] <= s8_side_reg;
            for (int j = 1; j < DIV_LAT; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
            lp1_reg     <= lp1_next;
            lp2_reg     <= lp2_next;
            l1_base_reg <= side_reg[DIV_LAT-1].base;
            out_reg     <= out_next;
        end
    end

    // ---------------- assertions ----------------
    `CPT_ASSERT_NEXT(a_stall_freeze, vld_reg[NSTG-1] && !m_tready, $stable(vld_reg), "valid line moved during a stall")
    `CPT_ASSERT_IMPL(a_face_den, vld_reg[ST8] && s8_side_reg.region == RG_FACE, din1_reg.den != '0, "face region with zero denominator")
    `CPT_ASSERT_IMPL(a_edge_ratio, vld_reg[ST_L1-1] && (side_reg[DIV_LAT-1].region == RG_AB || side_reg[DIV_LAT-1].region == RG_AC || side_reg[DIV_LAT-1].region == RG_BC), ratio1 >= 0 && ratio1 <= RATIO_ONE, "edge ratio outside zero to one")
    `CPT_ASSERT_IMPL(a_vertex_ratio, vld_reg[ST_L1-1] && (side_reg[DIV_LAT-1].region == RG_A || side_reg[DIV_LAT-1].region == RG_B || side_reg[DIV_LAT-1].region == RG_C), ratio1 == 0 && ratio2 == 0, "vertex region with nonzero ratio")

endmodule
